### design/motion_reactive_led_meter_defines.svh
// assertion macros for the motion reactive led meter
`ifndef MOTION_REACTIVE_LED_METER_DEFINES_SVH
`define MOTION_REACTIVE_LED_METER_DEFINES_SVH

// condition must hold in the same cycle
`define MRLM_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mrlm check failed");

// condition must hold in the following cycle
`define MRLM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mrlm check failed");

`endif

### design/mrlm_pkg.sv
// shared types, constants and helpers of the motion reactive led meter
package mrlm_pkg;

  localparam int LED_COUNT_DEF = 9;
  localparam int SAMPLE_W      = 16;
  localparam int OPND_W        = 16;
  localparam int SQ_W          = 32;
  localparam int STEP_CNT_W    = 4;
  localparam logic [STEP_CNT_W-1:0] LAST_STEP = 4'd15;

  // register map
  localparam int ADDR_W = 5;
  localparam logic [2:0] REG_SLEEP_TIMEOUT = 3'd0;
  localparam logic [2:0] REG_HOLDOFF       = 3'd1;
  localparam logic [2:0] REG_FULL_SCALE    = 3'd2;
  localparam logic [2:0] REG_LEVEL_WT      = 3'd3;
  localparam logic [2:0] REG_TINT_WT       = 3'd4;
  localparam logic [2:0] REG_DISPLAY_THR   = 3'd5;
  localparam logic [2:0] REG_WAKE_THR      = 3'd6;

  // register reset values
  localparam logic [15:0] RST_SLEEP_TIMEOUT = 16'd1000;
  localparam logic [7:0]  RST_HOLDOFF       = 8'd40;
  localparam logic [7:0]  RST_FULL_SCALE    = 8'd20;
  localparam logic [8:0]  RST_LEVEL_WT      = 9'd77;
  localparam logic [8:0]  RST_TINT_WT       = 9'd41;
  localparam logic [15:0] RST_DISPLAY_THR   = 16'd154;
  localparam logic [15:0] RST_WAKE_THR      = 16'd512;

  // fixed point constants (the 16-bit ones in Q8.8)
  localparam logic [15:0] GRAVITY      = 16'd2511;
  localparam logic [15:0] LEDS_FLOOR   = 16'd26;
  localparam logic [15:0] BRIGHT_FLOOR = 16'd512;
  localparam logic [7:0]  BRIGHT_BASE  = 8'd20;
  localparam logic [7:0]  BRIGHT_SPAN  = 8'd235;
  localparam logic [7:0]  HUE_SPAN     = 8'd255;
  localparam logic [8:0]  DECAY_ONE    = 9'd256;

  typedef struct packed {
    logic [15:0] sleep_timeout;
    logic [7:0]  holdoff;
    logic [7:0]  full_scale;
    logic [8:0]  level_weight;
    logic [8:0]  tint_weight;
    logic [15:0] display_thr;
    logic [15:0] wake_thr;
  } cfg_t;

  // magnitude of a signed sample
  function automatic logic [15:0] abs16(input logic [15:0] v);
    logic [15:0] r;
    r = v[15] ? 16'(16'd0 - v) : v;
    return r;
  endfunction

endpackage

### design/mrlm_if.sv
// handshake channels of the motion reactive led meter
interface mrlm_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] gyro_x;
  logic [15:0] gyro_y;
  logic [15:0] gyro_z;
  logic [15:0] accel_x;
  logic [15:0] accel_y;
  logic [15:0] accel_z;
  logic        motion_interrupt;
  logic        button_pressed;

  modport source (output valid, gyro_x, gyro_y, gyro_z, accel_x, accel_y, accel_z,
                  motion_interrupt, button_pressed, input ready);
  modport sink (input valid, gyro_x, gyro_y, gyro_z, accel_x, accel_y, accel_z,
                motion_interrupt, button_pressed, output ready);
endinterface

interface mrlm_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] led_index;
  logic [7:0] hue;
  logic [7:0] value;
  logic       bar_mode;
  logic       sleep_request;
  logic       last_led;

  modport source (output valid, led_index, hue, value, bar_mode, sleep_request, last_led,
                  input ready);
  modport sink (input valid, led_index, hue, value, bar_mode, sleep_request, last_led,
                output ready);
endinterface

### design/mrlm_mul.sv
// bit-serial shift-add multiplier, one multiplier bit per cycle
module mrlm_mul (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic [mrlm_pkg::OPND_W-1:0]      opa,
  input  logic [mrlm_pkg::OPND_W-1:0]      opb,
  output logic                             busy,
  output logic                             done,
  output logic [2*mrlm_pkg::OPND_W-1:0]    prod
);

  logic [mrlm_pkg::OPND_W-1:0]     a_r;
  logic [mrlm_pkg::OPND_W-1:0]     hi_r;
  logic [mrlm_pkg::OPND_W-1:0]     lo_r;
  logic [mrlm_pkg::STEP_CNT_W-1:0] cnt_r;
  logic                            busy_r;
  logic                            done_r;
  logic [mrlm_pkg::OPND_W:0]       sum;

  // add the multiplicand when the low bit is set
  assign sum = {1'b0, hi_r} + {1'b0, (lo_r[0] ? a_r : '0)};

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == mrlm_pkg::LAST_STEP) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // product shifts right one bit a cycle
  always_ff @(posedge clk) begin
    if (start) begin
      a_r  <= opa;
      hi_r <= '0;
      lo_r <= opb;
    end else if (busy_r) begin
      {hi_r, lo_r} <= {sum, lo_r[mrlm_pkg::OPND_W-1:1]};
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign prod = {hi_r, lo_r};

endmodule

### design/mrlm_sqrt.sv
// digit-serial integer square root, two radicand bits per cycle
module mrlm_sqrt (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [mrlm_pkg::SQ_W-1:0]    radicand,
  output logic                         busy,
  output logic                         done,
  output logic [mrlm_pkg::OPND_W-1:0]  root
);

  logic [mrlm_pkg::SQ_W-1:0]       x_r;
  logic [17:0]                     rem_r;
  logic [mrlm_pkg::OPND_W-1:0]     root_r;
  logic [mrlm_pkg::STEP_CNT_W-1:0] cnt_r;
  logic                            busy_r;
  logic                            done_r;
  logic [19:0]                     rem_in;
  logic [19:0]                     trial;
  logic                            fits;

  // bring down two bits and try the next root digit
  assign rem_in = {rem_r, x_r[mrlm_pkg::SQ_W-1 -: 2]};
  assign trial  = {2'b00, root_r, 2'b01};
  assign fits   = (rem_in >= trial);

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == mrlm_pkg::LAST_STEP) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      x_r    <= radicand;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      x_r    <= {x_r[mrlm_pkg::SQ_W-3:0], 2'b00};
      rem_r  <= fits ? 18'(rem_in - trial) : rem_in[17:0];
      root_r <= {root_r[mrlm_pkg::OPND_W-2:0], fits};
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign root = root_r;

endmodule

### design/mrlm_div.sv
// restoring divider, one quotient bit per cycle
module mrlm_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [mrlm_pkg::OPND_W-1:0]  dividend,
  input  logic [7:0]                   divisor,
  output logic                         busy,
  output logic                         done,
  output logic [mrlm_pkg::OPND_W-1:0]  quot
);

  logic [mrlm_pkg::OPND_W-1:0]     q_r;
  logic [7:0]                      rem_r;
  logic [7:0]                      d_r;
  logic [mrlm_pkg::STEP_CNT_W-1:0] cnt_r;
  logic                            busy_r;
  logic                            done_r;
  logic [8:0]                      part;
  logic                            fits;

  // shift in the next dividend bit and compare
  assign part = {rem_r, q_r[mrlm_pkg::OPND_W-1]};
  assign fits = (part >= {1'b0, d_r});

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == mrlm_pkg::LAST_STEP) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      rem_r <= '0;
      d_r   <= divisor;
    end else if (busy_r) begin
      rem_r <= fits ? 8'(part - {1'b0, d_r}) : part[7:0];
      q_r   <= {q_r[mrlm_pkg::OPND_W-2:0], fits};
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign quot = q_r;

endmodule

### design/mrlm_cfg.sv
// configuration register file behind the apb-style port
module mrlm_cfg (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [mrlm_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  output mrlm_pkg::cfg_t               cfg
);

  mrlm_pkg::cfg_t cfg_r;
  logic [2:0]     idx;
  logic           wr;

  assign idx    = paddr[4:2];
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sleep_timeout <= mrlm_pkg::RST_SLEEP_TIMEOUT;
      cfg_r.holdoff       <= mrlm_pkg::RST_HOLDOFF;
      cfg_r.full_scale    <= mrlm_pkg::RST_FULL_SCALE;
      cfg_r.level_weight  <= mrlm_pkg::RST_LEVEL_WT;
      cfg_r.tint_weight   <= mrlm_pkg::RST_TINT_WT;
      cfg_r.display_thr   <= mrlm_pkg::RST_DISPLAY_THR;
      cfg_r.wake_thr      <= mrlm_pkg::RST_WAKE_THR;
    end else if (wr) begin
      case (idx)
        mrlm_pkg::REG_SLEEP_TIMEOUT: cfg_r.sleep_timeout <= pwdata[15:0];
        mrlm_pkg::REG_HOLDOFF:       cfg_r.holdoff       <= pwdata[7:0];
        mrlm_pkg::REG_FULL_SCALE:    cfg_r.full_scale    <= pwdata[7:0];
        mrlm_pkg::REG_LEVEL_WT:      cfg_r.level_weight  <= pwdata[8:0];
        mrlm_pkg::REG_TINT_WT:       cfg_r.tint_weight   <= pwdata[8:0];
        mrlm_pkg::REG_DISPLAY_THR:   cfg_r.display_thr   <= pwdata[15:0];
        mrlm_pkg::REG_WAKE_THR:      cfg_r.wake_thr      <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    case (idx)
      mrlm_pkg::REG_SLEEP_TIMEOUT: prdata = {16'd0, cfg_r.sleep_timeout};
      mrlm_pkg::REG_HOLDOFF:       prdata = {24'd0, cfg_r.holdoff};
      mrlm_pkg::REG_FULL_SCALE:    prdata = {24'd0, cfg_r.full_scale};
      mrlm_pkg::REG_LEVEL_WT:      prdata = {23'd0, cfg_r.level_weight};
      mrlm_pkg::REG_TINT_WT:       prdata = {23'd0, cfg_r.tint_weight};
      mrlm_pkg::REG_DISPLAY_THR:   prdata = {16'd0, cfg_r.display_thr};
      mrlm_pkg::REG_WAKE_THR:      prdata = {16'd0, cfg_r.wake_thr};
      default:                     prdata = 32'd0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

### design/motion_reactive_led_meter.sv
// top level of the motion reactive led meter: sequencer, state and result register
//
// in_ch takes one sensor frame (gyro and accel in signed Q7.8, motion interrupt,
// button level). in_ch.ready is high only while the sequencer is idle.
// Each frame yields LED_COUNT words on out_ch, led_index 0 first, last_led set on
// the final one. The apb-style port (psel..pready, pready always high) sets the
// registers at byte address 4*i; write it only while no frame is in flight.
// Each frame runs through a micro-sequence of 15 multiplies, 2 square roots
// and 3 divides, each on a bit-serial unit of 16 steps, issued in ST_ISSUE and
// awaited in ST_WAIT; a frame not above the display threshold skips 3 multiplies
// and the 3 divides. The words then follow at one word per cycle while
// out_ch.ready is high. The next frame is taken only after all words of the
// current one are loaded.
// Reset (rst_n low, synchronous) restores register defaults, clears the smoothed
// targets and counters, selects full strip mode and arms the button; in_ch.ready
// stays low while rst_n is low.
// A stalled receiver holds the current word in the output register; the
// sequencer waits, and the next frame is taken once all words are loaded.
`include "motion_reactive_led_meter_defines.svh"

module motion_reactive_led_meter #(
  parameter int LED_COUNT = mrlm_pkg::LED_COUNT_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  mrlm_in_if.sink                      in_ch,
  mrlm_out_if.source                   out_ch,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [mrlm_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  localparam int IW = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
  localparam logic [IW-1:0] LAST_IDX = IW'(LED_COUNT - 1);

  // sequencer states
  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_ISSUE = 2'd1;
  localparam logic [1:0] ST_WAIT  = 2'd2;
  localparam logic [1:0] ST_EMIT  = 2'd3;

  // micro steps
  localparam logic [4:0] U_GX    = 5'd0;
  localparam logic [4:0] U_GY    = 5'd1;
  localparam logic [4:0] U_GZ    = 5'd2;
  localparam logic [4:0] U_GROOT = 5'd3;
  localparam logic [4:0] U_AX    = 5'd4;
  localparam logic [4:0] U_AY    = 5'd5;
  localparam logic [4:0] U_AZ    = 5'd6;
  localparam logic [4:0] U_AROOT = 5'd7;
  localparam logic [4:0] U_LMUL  = 5'd8;
  localparam logic [4:0] U_LDIV  = 5'd9;
  localparam logic [4:0] U_HMUL  = 5'd10;
  localparam logic [4:0] U_HDIV  = 5'd11;
  localparam logic [4:0] U_BMUL  = 5'd12;
  localparam logic [4:0] U_BDIV  = 5'd13;
  localparam logic [4:0] U_LKEEP = 5'd14;
  localparam logic [4:0] U_LNEW  = 5'd15;
  localparam logic [4:0] U_HKEEP = 5'd16;
  localparam logic [4:0] U_HNEW  = 5'd17;
  localparam logic [4:0] U_BKEEP = 5'd18;
  localparam logic [4:0] U_BNEW  = 5'd19;

  mrlm_pkg::cfg_t cfg;

  logic [1:0]    state_r;
  logic [4:0]    ustep_r;
  logic [IW-1:0] i_r;
  logic [15:0]   abs_r [6];
  logic          irq_r;
  logic [31:0]   acc_r;
  logic [15:0]   gyro_r;
  logic [7:0]    m_r;
  logic [7:0]    fs_r;
  logic [7:0]    tl_r;
  logic [7:0]    th_r;
  logic [7:0]    tb_r;
  logic [15:0]   sl_r;
  logic [15:0]   sh_r;
  logic [15:0]   sb_r;
  logic          mode_r;
  logic [15:0]   idle_r;
  logic [7:0]    hold_r;

  logic          out_valid_r;
  logic [3:0]    out_idx_r;
  logic [7:0]    out_hue_r;
  logic [7:0]    out_val_r;
  logic          out_bar_r;
  logic          out_sleep_r;
  logic          out_last_r;

  // unit signals
  logic          mul_start;
  logic          sqrt_start;
  logic          div_start;
  logic          mul_busy;
  logic          sqrt_busy;
  logic          div_busy;
  logic          mul_done;
  logic          sqrt_done;
  logic          div_done;
  logic [15:0]   mul_a;
  logic [15:0]   mul_b;
  logic [31:0]   mul_p;
  logic [15:0]   root;
  logic [15:0]   quot;
  logic          unit_done;

  mrlm_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  mrlm_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .opa   (mul_a),
    .opb   (mul_b),
    .busy  (mul_busy),
    .done  (mul_done),
    .prod  (mul_p)
  );

  mrlm_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sqrt_start),
    .radicand (acc_r),
    .busy     (sqrt_busy),
    .done     (sqrt_done),
    .root     (root)
  );

  mrlm_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (acc_r[15:0]),
    .divisor  (fs_r),
    .busy     (div_busy),
    .done     (div_done),
    .quot     (quot)
  );

  assign unit_done = mul_done || sqrt_done || div_done;

  // decay weights saturated at one
  logic [8:0] md_sat;
  logic [8:0] hd_sat;
  assign md_sat = (cfg.level_weight > mrlm_pkg::DECAY_ONE) ? mrlm_pkg::DECAY_ONE
                                                            : cfg.level_weight;
  assign hd_sat = (cfg.tint_weight > mrlm_pkg::DECAY_ONE) ? mrlm_pkg::DECAY_ONE
                                                           : cfg.tint_weight;

  // unit selection and operands per micro step
  always_comb begin
    mul_start  = 1'b0;
    sqrt_start = 1'b0;
    div_start  = 1'b0;
    mul_a      = '0;
    mul_b      = '0;
    case (ustep_r)
      U_GX:    begin mul_a = abs_r[0]; mul_b = abs_r[0]; end
      U_GY:    begin mul_a = abs_r[1]; mul_b = abs_r[1]; end
      U_GZ:    begin mul_a = abs_r[2]; mul_b = abs_r[2]; end
      U_AX:    begin mul_a = abs_r[3]; mul_b = abs_r[3]; end
      U_AY:    begin mul_a = abs_r[4]; mul_b = abs_r[4]; end
      U_AZ:    begin mul_a = abs_r[5]; mul_b = abs_r[5]; end
      U_LMUL:  begin mul_a = {8'd0, m_r}; mul_b = 16'(LED_COUNT); end
      U_HMUL:  begin mul_a = {8'd0, m_r}; mul_b = {8'd0, mrlm_pkg::HUE_SPAN}; end
      U_BMUL:  begin mul_a = {8'd0, m_r}; mul_b = {8'd0, mrlm_pkg::BRIGHT_SPAN}; end
      U_LKEEP: begin mul_a = sl_r; mul_b = {7'd0, 9'(mrlm_pkg::DECAY_ONE - md_sat)}; end
      U_LNEW:  begin mul_a = {8'd0, tl_r}; mul_b = {7'd0, md_sat}; end
      U_HKEEP: begin mul_a = sh_r; mul_b = {7'd0, 9'(mrlm_pkg::DECAY_ONE - hd_sat)}; end
      U_HNEW:  begin mul_a = {8'd0, th_r}; mul_b = {7'd0, hd_sat}; end
      U_BKEEP: begin mul_a = sb_r; mul_b = {7'd0, 9'(mrlm_pkg::DECAY_ONE - md_sat)}; end
      U_BNEW:  begin mul_a = {8'd0, tb_r}; mul_b = {7'd0, md_sat}; end
      default: ;
    endcase
    if (state_r == ST_ISSUE) begin
      case (ustep_r)
        U_GROOT, U_AROOT:        sqrt_start = 1'b1;
        U_LDIV, U_HDIV, U_BDIV:  div_start  = 1'b1;
        default:                 mul_start  = 1'b1;
      endcase
    end
  end

  // motion figure once the accel root is out
  logic [15:0] adev;
  logic [16:0] motion;
  logic [8:0]  m_int;
  logic [7:0]  fs_eff;
  logic        hit;
  logic        wake;
  assign adev   = (root >= mrlm_pkg::GRAVITY) ? 16'(root - mrlm_pkg::GRAVITY)
                                              : 16'(mrlm_pkg::GRAVITY - root);
  assign motion = {1'b0, gyro_r} + {1'b0, adev};
  assign m_int  = motion[16:8];
  assign fs_eff = (cfg.full_scale == 8'd0) ? 8'd1 : cfg.full_scale;
  assign hit    = (motion > {1'b0, cfg.display_thr});
  assign wake   = (motion > {1'b0, cfg.wake_thr}) || irq_r;

  // smoothed value: (keep + new*256) >> 8
  logic [25:0] smooth_sum;
  logic [15:0] smooth_nxt;
  assign smooth_sum = acc_r[25:0] + {mul_p[17:0], 8'd0};
  assign smooth_nxt = smooth_sum[23:8];

  // per-led result
  logic [16:0] lit_sum;
  logic [8:0]  lit;
  logic [8:0]  idx9;
  logic [8:0]  frac;
  logic [16:0] frac_scaled;
  logic [7:0]  hue_nxt;
  logic [7:0]  val_nxt;
  assign lit_sum     = {1'b0, sl_r} + 17'd255;
  assign lit         = lit_sum[16:8];
  assign idx9        = 9'(i_r);
  assign frac        = (sl_r[7:0] == 8'd0) ? 9'd256 : {1'b0, sl_r[7:0]};
  assign frac_scaled = {frac, 8'd0} - {8'd0, frac};

  always_comb begin
    hue_nxt = 8'd0;
    val_nxt = 8'd0;
    if (mode_r) begin
      hue_nxt = sh_r[15:8];
      val_nxt = sb_r[15:8];
    end else if (idx9 < lit) begin
      hue_nxt = sh_r[15:8] + 8'({i_r, 3'b000});
      val_nxt = (idx9 == 9'(lit - 9'd1)) ? frac_scaled[15:8] : 8'd255;
    end
  end

  logic in_ready;
  logic in_fire;
  logic out_load;
  assign in_ready = rst_n && (state_r == ST_IDLE);
  assign in_fire  = in_ch.valid && in_ready;
  assign out_load = (state_r == ST_EMIT) && (!out_valid_r || out_ch.ready);

  // sequencer and frame state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ustep_r <= U_GX;
      i_r     <= '0;
      sl_r    <= '0;
      sh_r    <= '0;
      sb_r    <= '0;
      mode_r  <= 1'b1;
      idle_r  <= '0;
      hold_r  <= 8'hFF;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (in_fire) begin
            state_r <= ST_ISSUE;
            ustep_r <= U_GX;
            // mode button with holdoff
            if (in_ch.button_pressed && (hold_r >= cfg.holdoff)) begin
              mode_r <= !mode_r;
              hold_r <= '0;
            end else if (hold_r != 8'hFF) begin
              hold_r <= hold_r + 8'd1;
            end
          end
        end
        ST_ISSUE: state_r <= ST_WAIT;
        ST_WAIT: begin
          if (unit_done) begin
            case (ustep_r)
              U_AROOT: begin
                if (wake) begin
                  idle_r <= '0;
                end else if (idle_r != 16'hFFFF) begin
                  idle_r <= idle_r + 16'd1;
                end
                // targets stay zero under the display threshold
                state_r <= ST_ISSUE;
                ustep_r <= hit ? U_LMUL : U_LKEEP;
              end
              U_LNEW: begin
                sl_r    <= (smooth_nxt < mrlm_pkg::LEDS_FLOOR) ? 16'd0 : smooth_nxt;
                state_r <= ST_ISSUE;
                ustep_r <= ustep_r + 5'd1;
              end
              U_HNEW: begin
                sh_r    <= smooth_nxt;
                state_r <= ST_ISSUE;
                ustep_r <= ustep_r + 5'd1;
              end
              U_BNEW: begin
                sb_r    <= (smooth_nxt < mrlm_pkg::BRIGHT_FLOOR) ? 16'd0 : smooth_nxt;
                state_r <= ST_EMIT;
                i_r     <= '0;
              end
              default: begin
                state_r <= ST_ISSUE;
                ustep_r <= ustep_r + 5'd1;
              end
            endcase
          end
        end
        ST_EMIT: begin
          if (out_load) begin
            i_r <= i_r + 1'b1;
            if (i_r == LAST_IDX) begin
              state_r <= ST_IDLE;
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // frame datapath
  always_ff @(posedge clk) begin
    if (in_fire) begin
      abs_r[0] <= mrlm_pkg::abs16(in_ch.gyro_x);
      abs_r[1] <= mrlm_pkg::abs16(in_ch.gyro_y);
      abs_r[2] <= mrlm_pkg::abs16(in_ch.gyro_z);
      abs_r[3] <= mrlm_pkg::abs16(in_ch.accel_x);
      abs_r[4] <= mrlm_pkg::abs16(in_ch.accel_y);
      abs_r[5] <= mrlm_pkg::abs16(in_ch.accel_z);
      irq_r    <= in_ch.motion_interrupt;
      acc_r    <= '0;
    end else if ((state_r == ST_WAIT) && unit_done) begin
      case (ustep_r)
        U_GX, U_GY, U_GZ, U_AX, U_AY, U_AZ: acc_r <= acc_r + mul_p;
        U_GROOT: begin
          gyro_r <= root;
          acc_r  <= '0;
        end
        U_AROOT: begin
          fs_r <= fs_eff;
          m_r  <= (m_int > {1'b0, fs_eff}) ? fs_eff : m_int[7:0];
          tl_r <= '0;
          th_r <= '0;
          tb_r <= '0;
        end
        U_LMUL, U_HMUL, U_BMUL, U_LKEEP, U_HKEEP, U_BKEEP: acc_r <= mul_p;
        U_LDIV:  tl_r <= (quot[7:0] == 8'd0) ? 8'd1 : quot[7:0];
        U_HDIV:  th_r <= quot[7:0];
        U_BDIV:  tb_r <= 8'(mrlm_pkg::BRIGHT_BASE + quot[7:0]);
        default: ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_idx_r   <= 4'(i_r);
      out_hue_r   <= hue_nxt;
      out_val_r   <= val_nxt;
      out_bar_r   <= !mode_r;
      out_sleep_r <= (idle_r > cfg.sleep_timeout);
      out_last_r  <= (i_r == LAST_IDX);
    end
  end

  assign in_ch.ready          = in_ready;
  assign out_ch.valid         = out_valid_r;
  assign out_ch.led_index     = out_idx_r;
  assign out_ch.hue           = out_hue_r;
  assign out_ch.value         = out_val_r;
  assign out_ch.bar_mode      = out_bar_r;
  assign out_ch.sleep_request = out_sleep_r;
  assign out_ch.last_led      = out_last_r;

  // checks
  `MRLM_ASSERT_SAME(a_one_unit, 1'b1, $onehot0({mul_busy, sqrt_busy, div_busy}))
  `MRLM_ASSERT_NEXT(a_frame_starts, in_ch.valid && in_ch.ready, state_r == ST_ISSUE)
  `MRLM_ASSERT_NEXT(a_last_ends, out_load && i_r == LAST_IDX, state_r == ST_IDLE && out_last_r)

endmodule

### sim/tb_motion_reactive_led_meter.sv
// testbench for the motion reactive led meter: directed and random frames against a predictor
module tb_motion_reactive_led_meter;

  localparam int LEDS = 9;
  localparam int CYCLE_LIMIT = 1500000;

  typedef struct packed {
    logic [3:0] led_index;
    logic [7:0] hue;
    logic [7:0] value;
    logic       bar_mode;
    logic       sleep_request;
    logic       last_led;
  } led_word_t;

  logic clk;
  logic rst_n;
  logic psel, penable, pwrite;
  logic [mrlm_pkg::ADDR_W-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  mrlm_in_if in_ch();
  mrlm_out_if out_ch();

  motion_reactive_led_meter dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // predictor state and register copy
  logic [15:0] p_sleep_timeout;
  logic [7:0]  p_holdoff_cfg;
  logic [7:0]  p_full_scale;
  logic [8:0]  p_level_wt;
  logic [8:0]  p_tint_wt;
  logic [15:0] p_display_thr;
  logic [15:0] p_wake_thr;
  logic [31:0] s_leds, s_hue, s_bright;
  logic        strip_mode;
  logic [15:0] idle_cnt;
  logic [7:0]  holdoff_cnt;

  led_word_t expected_words[$];
  int errors = 0;
  int cycles = 0;
  bit stalls_on = 1;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // cycle limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic logic [31:0] isqrt(input logic [31:0] x);
    logic [31:0] res, bitv;
    res = 0;
    bitv = 32'h4000_0000;
    while (bitv > x) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x = x - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic logic [31:0] vec_mag(input logic [15:0] a, input logic [15:0] b,
                                          input logic [15:0] c);
    logic [31:0] ua, ub, uc;
    ua = a[15] ? 32'h10000 - a : 32'(a);
    ub = b[15] ? 32'h10000 - b : 32'(b);
    uc = c[15] ? 32'h10000 - c : 32'(c);
    return isqrt(ua * ua + ub * ub + uc * uc);
  endfunction

  function automatic logic [31:0] ema(input logic [31:0] cur, input logic [31:0] tgt,
                                      input logic [8:0] d);
    logic [31:0] dd;
    dd = (d > 256) ? 256 : 32'(d);
    return (cur * (256 - dd) + tgt * 256 * dd) >> 8;
  endfunction

  // advance the predictor by one frame and queue its nine words
  task automatic predict_frame(input logic [15:0] gx, gy, gz, ax, ay, az,
                               input logic irq, btn);
    logic [31:0] gmag, amag, adev, motion, fs, m, t_l, t_h, t_b, lit, h, v;
    logic [7:0] hue0;
    logic sreq;
    led_word_t w;
    if (btn && holdoff_cnt >= p_holdoff_cfg) begin
      strip_mode = ~strip_mode;
      holdoff_cnt = 0;
    end else if (holdoff_cnt < 255) begin
      holdoff_cnt++;
    end
    gmag = vec_mag(gx, gy, gz);
    amag = vec_mag(ax, ay, az);
    adev = (amag >= mrlm_pkg::GRAVITY) ? amag - mrlm_pkg::GRAVITY
                                       : mrlm_pkg::GRAVITY - amag;
    motion = gmag + adev;
    if (motion > p_wake_thr || irq) idle_cnt = 0;
    else if (idle_cnt < 16'hFFFF) idle_cnt++;
    t_l = 0; t_h = 0; t_b = 0;
    if (motion > p_display_thr) begin
      fs = (p_full_scale == 0) ? 1 : 32'(p_full_scale);
      m = motion >> 8;
      if (m > fs) m = fs;
      t_l = m * LEDS / fs;
      if (t_l < 1) t_l = 1;
      t_h = m * 255 / fs;
      t_b = 20 + m * 235 / fs;
    end
    s_leds = ema(s_leds, t_l, p_level_wt);
    s_hue = ema(s_hue, t_h, p_tint_wt);
    s_bright = ema(s_bright, t_b, p_level_wt);
    if (s_leds < mrlm_pkg::LEDS_FLOOR) s_leds = 0;
    if (s_bright < mrlm_pkg::BRIGHT_FLOOR) s_bright = 0;
    sreq = idle_cnt > p_sleep_timeout;
    hue0 = s_hue[15:8];
    lit = (s_leds + 255) >> 8;
    for (int i = 0; i < LEDS; i++) begin
      h = 0; v = 0;
      if (strip_mode) begin
        h = 32'(hue0);
        v = (s_bright >> 8) & 8'hFF;
      end else if (i < lit) begin
        h = (hue0 + i * 8) & 8'hFF;
        v = 255;
        if (i == lit - 1) v = (((s_leds - i * 256) * 255) >> 8) & 8'hFF;
      end
      w.led_index = 4'(i);
      w.hue = h[7:0];
      w.value = v[7:0];
      w.bar_mode = ~strip_mode;
      w.sleep_request = sreq;
      w.last_led = (i == LEDS - 1);
      expected_words.push_back(w);
    end
  endtask

  // receiver stall pattern and result check
  initial begin
    out_ch.ready = 0;
    forever begin
      @(negedge clk);
      if (!stalls_on) out_ch.ready <= 1;
      else case ($urandom_range(0, 3))
        0: out_ch.ready <= 0;
        default: out_ch.ready <= 1;
      endcase
    end
  end

  always @(posedge clk) begin
    led_word_t got, exp_w;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = '{out_ch.led_index, out_ch.hue, out_ch.value, out_ch.bar_mode,
              out_ch.sleep_request, out_ch.last_led};
      if (expected_words.size() == 0) begin
        $display("%0t unexpected word %h", $time, got);
        errors++;
      end else begin
        exp_w = expected_words.pop_front();
        if (got.led_index != exp_w.led_index)
          $display("%0t led_index exp %0d got %0d", $time, exp_w.led_index, got.led_index);
        if (got.hue != exp_w.hue)
          $display("%0t hue exp %0d got %0d", $time, exp_w.hue, got.hue);
        if (got.value != exp_w.value)
          $display("%0t value exp %0d got %0d", $time, exp_w.value, got.value);
        if (got.bar_mode != exp_w.bar_mode)
          $display("%0t bar_mode exp %0d got %0d", $time, exp_w.bar_mode, got.bar_mode);
        if (got.sleep_request != exp_w.sleep_request)
          $display("%0t sleep_request exp %0d got %0d", $time, exp_w.sleep_request,
                   got.sleep_request);
        if (got.last_led != exp_w.last_led)
          $display("%0t last_led exp %0d got %0d", $time, exp_w.last_led, got.last_led);
        if (got != exp_w) errors++;
      end
    end
  end

  // send one frame, with a random gap in front at burst ends
  int burst_left = 0;
  task automatic send_frame(input logic [15:0] gx, gy, gz, ax, ay, az,
                            input logic irq, btn);
    @(negedge clk);
    if (burst_left == 0) begin
      repeat ($urandom_range(0, 20)) @(negedge clk);
      burst_left = $urandom_range(1, 8);
    end
    burst_left--;
    in_ch.valid <= 1;
    in_ch.gyro_x <= gx; in_ch.gyro_y <= gy; in_ch.gyro_z <= gz;
    in_ch.accel_x <= ax; in_ch.accel_y <= ay; in_ch.accel_z <= az;
    in_ch.motion_interrupt <= irq; in_ch.button_pressed <= btn;
    do @(posedge clk); while (!in_ch.ready);
    predict_frame(gx, gy, gz, ax, ay, az, irq, btn);
    @(negedge clk);
    in_ch.valid <= 0;
  endtask

  // wait for all words, then let the sequencer settle
  task automatic drain();
    while (expected_words.size() != 0) @(negedge clk);
    repeat (400) @(negedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    @(negedge clk);
    psel <= 1; penable <= 0; pwrite <= 1;
    paddr <= mrlm_pkg::ADDR_W'({idx, 2'b00}); pwdata <= val;
    @(negedge clk);
    penable <= 1;
    @(negedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    case (idx)
      mrlm_pkg::REG_SLEEP_TIMEOUT: p_sleep_timeout = val[15:0];
      mrlm_pkg::REG_HOLDOFF:       p_holdoff_cfg = val[7:0];
      mrlm_pkg::REG_FULL_SCALE:    p_full_scale = val[7:0];
      mrlm_pkg::REG_LEVEL_WT:      p_level_wt = val[8:0];
      mrlm_pkg::REG_TINT_WT:       p_tint_wt = val[8:0];
      mrlm_pkg::REG_DISPLAY_THR:   p_display_thr = val[15:0];
      mrlm_pkg::REG_WAKE_THR:      p_wake_thr = val[15:0];
      default: ;
    endcase
  endtask

  task automatic set_all(input logic [15:0] st, input logic [7:0] ho, fs,
                         input logic [8:0] md, hd, input logic [15:0] dt, wt);
    write_reg(mrlm_pkg::REG_SLEEP_TIMEOUT, 32'(st));
    write_reg(mrlm_pkg::REG_HOLDOFF, 32'(ho));
    write_reg(mrlm_pkg::REG_FULL_SCALE, 32'(fs));
    write_reg(mrlm_pkg::REG_LEVEL_WT, 32'(md));
    write_reg(mrlm_pkg::REG_TINT_WT, 32'(hd));
    write_reg(mrlm_pkg::REG_DISPLAY_THR, 32'(dt));
    write_reg(mrlm_pkg::REG_WAKE_THR, 32'(wt));
  endtask

  function automatic logic [15:0] rnd_sample();
    case ($urandom_range(0, 3))
      0: return 16'($urandom);
      1: return 16'($urandom_range(0, 1200)) - 16'd600;
      2: return $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
      default: return 16'($urandom_range(0, 3000));
    endcase
  endfunction

  // resting frame with gravity on z, then extreme and mixed samples, interrupts and button presses
  task automatic test_extremes();
    send_frame(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd2511, 1'b0, 1'b0);
    send_frame(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b0, 1'b0);
    send_frame(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 1'b1, 1'b0);
    send_frame(16'hFFFF, 16'h0001, 16'h8001, 16'd0, 16'd0, 16'd0, 1'b0, 1'b0);
    send_frame(16'd1000, 16'd500, 16'd0, 16'd0, 16'd2511, 16'd0, 1'b1, 1'b1);
    send_frame(16'd3000, 16'd0, 16'd0, 16'd0, 16'd0, 16'd2600, 1'b0, 1'b1);
    send_frame(16'd300, 16'd0, 16'd0, 16'd0, 16'd0, 16'd2511, 1'b0, 1'b0);
    send_frame(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd2511, 1'b0, 1'b0);
    drain();
  endtask

  // bar mode with zero holdoff, button toggles and a short sleep timeout, then a long holdoff
  task automatic test_bar_and_sleep();
    set_all(16'd1, 8'd0, 8'd1, 9'd256, 9'd256, 16'd0, 16'hFFFF);
    send_frame(16'd5000, 16'd0, 16'd0, 16'd0, 16'd0, 16'd2511, 1'b0, 1'b1);
    for (int i = 0; i < 6; i++)
      send_frame(16'(i * 400), 16'd0, 16'd0, 16'd0, 16'd0, 16'd2511, 1'b0, i[0]);
    drain();
    set_all(16'hFFFF, 8'd255, 8'd0, 9'd300, 9'd0, 16'hFFFF, 16'd0);
    for (int i = 0; i < 4; i++)
      send_frame(rnd_sample(), rnd_sample(), 16'd0, 16'd0, 16'd0, 16'd2511, 1'b0, 1'b1);
    drain();
  endtask

  // random frames over several register settings
  task automatic test_random();
    logic [15:0] az;
    for (int phase = 0; phase < 5; phase++) begin
      set_all(16'($urandom_range(1, 40)), 8'($urandom_range(0, 6)),
              8'($urandom_range(1, 255)), 9'($urandom_range(0, 511)),
              9'($urandom_range(0, 511)), 16'($urandom_range(0, 3000)),
              16'($urandom_range(0, 65535)));
      if (phase == 4) set_all(16'd1000, 8'd40, 8'd20, 9'd77, 9'd41, 16'd154, 16'd512);
      stalls_on = (phase != 2);
      for (int i = 0; i < 70; i++) begin
        az = ($urandom_range(0, 3) == 0) ? rnd_sample() : 16'd2511 + 16'($urandom_range(0, 40));
        send_frame(rnd_sample(), rnd_sample(), rnd_sample(), rnd_sample(), rnd_sample(), az,
                   $urandom_range(0, 7) == 0, $urandom_range(0, 3) == 0);
        if (i == 35) while (expected_words.size() != 0) @(negedge clk);
      end
      drain();
    end
  endtask

  initial begin
    rst_n = 0;
    psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
    in_ch.valid = 0;
    in_ch.gyro_x = 0; in_ch.gyro_y = 0; in_ch.gyro_z = 0;
    in_ch.accel_x = 0; in_ch.accel_y = 0; in_ch.accel_z = 0;
    in_ch.motion_interrupt = 0; in_ch.button_pressed = 0;
    p_sleep_timeout = 1000; p_holdoff_cfg = 40; p_full_scale = 20;
    p_level_wt = 77; p_tint_wt = 41; p_display_thr = 154; p_wake_thr = 512;
    s_leds = 0; s_hue = 0; s_bright = 0; strip_mode = 1; idle_cnt = 0; holdoff_cnt = 255;
    repeat (3) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);
    test_extremes();
    test_bar_and_sleep();
    test_random();
    if (errors == 0 && expected_words.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
